// ----- sv/pps_pkg.sv -----
// Package for the preemptive priority scheduler: item types, entry layout, FSM states.
`default_nettype none
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  // Command codes carried in the cmd field
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [15:0] ready_at;
    logic [15:0] burst_length;
    logic [7:0]  prio_level;
  } in_t;

  typedef struct packed {
    logic [3:0]  chosen_slot;
    logic        idle;
    logic        completed;
    logic [15:0] wait_ticks;
    logic [15:0] now_tick;
  } out_t;

  // One row of the process table memory
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD
  } state_t;

endpackage
`default_nettype wire

// ----- sv/preemptive_priority_scheduler_core.sv -----
// Top level of the preemptive priority scheduler: process table memory, scan and update.
// Load item: written in the accept cycle, busy stays low, one load per cycle while idle.
// Tick item: slots are read from the table memory one per cycle in the scan state, with
// n = min(count, MAX_PROCS); drain and update states follow and the result strobe is
// registered from update (no scan when n is 0); the next item may be accepted as it shows.
// Reset clears the FSM, finished flags, time counter and sets process_count to 1;
// table rows hold nothing defined until a load writes them.
`default_nettype none
module preemptive_priority_scheduler_core #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire pps_pkg::in_t item,
  output pps_pkg::out_t     result,
  output logic              result_valid,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [4:0]   cfg_data
);
  import pps_pkg::*;

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  state_t state, state_next;

  logic [4:0]           process_count;
  logic [15:0]          tick;
  logic [MAX_PROCS-1:0] fin;

  entry_t mem [MAX_PROCS];
  entry_t rd_data;

  logic [IW-1:0] cnt;
  logic          ev_vld;
  logic [IW-1:0] ev_idx;

  logic          found;
  logic [IW-1:0] best_idx;
  entry_t        best;

  logic          accept, load_acc, tick_acc, load_ok;
  logic          issue, upd;
  logic [CW-1:0] n_eff;
  logic          last_issue;
  logic          take;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [15:0]   rem_new, now_new;
  logic          done_now;

  assign cfg_ready = 1'b1;

  assign accept   = start && !busy;
  assign load_acc = accept && (item.cmd == CMD_LOAD);
  assign tick_acc = accept && (item.cmd == CMD_TICK);
  assign load_ok  = {28'd0, item.slot} < 32'(MAX_PROCS);

  // Saturate the slot count to the table depth
  always_comb begin
    if (32'(process_count) > 32'(MAX_PROCS)) begin
      n_eff = CW'(MAX_PROCS);
    end else begin
      n_eff = CW'(process_count);
    end
  end

  assign last_issue = (CW'(cnt) + CW'(1)) == n_eff;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_acc) begin
          state_next = (n_eff == '0) ? ST_UPD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_UPD;
      ST_UPD:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    upd   = 1'b0;
    unique case (state)
      ST_IDLE:  busy  = 1'b0;
      ST_SCAN:  issue = 1'b1;
      ST_DRAIN: ;
      ST_UPD:   upd   = 1'b1;
      default:  busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Compare the entry read last cycle against the running best
  assign take = ev_vld && !fin[ev_idx] && (rd_data.arrival <= tick) &&
                (!found || (rd_data.prio > best.prio) ||
                 ((rd_data.prio == best.prio) && (rd_data.arrival < best.arrival)));

  assign rem_new  = (best.remaining != 16'd0) ? best.remaining - 16'd1 : 16'd0;
  assign now_new  = tick + 16'd1;
  assign done_now = found && (rem_new == 16'd0);

  // Single write port: loads in idle, remaining write-back in update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(item.slot);
    wr_data = '{arrival:   item.ready_at,
                burst:     item.burst_length,
                remaining: item.burst_length,
                prio:      item.prio_level};
    if (upd) begin
      wr_en   = found;
      wr_addr = best_idx;
      wr_data = '{arrival: best.arrival, burst: best.burst,
                  remaining: rem_new, prio: best.prio};
    end else if (load_acc && load_ok) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= 5'd1;
      tick          <= '0;
      fin           <= '0;
      cnt           <= '0;
      ev_vld        <= 1'b0;
      found         <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        process_count <= cfg_data;
      end
      ev_vld       <= issue;
      result_valid <= upd;
      if (issue) begin
        cnt <= cnt + IW'(1);
      end
      if (tick_acc) begin
        cnt   <= '0;
        found <= 1'b0;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (load_acc && load_ok) begin
        fin[IW'(item.slot)] <= (item.burst_length == 16'd0);
      end
      if (upd) begin
        tick <= now_new;
        if (done_now) begin
          fin[best_idx] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ev_idx <= cnt;
    if (take) begin
      best_idx <= ev_idx;
      best     <= rd_data;
    end
    if (upd) begin
      result.chosen_slot <= found ? 4'(best_idx) : 4'd0;
      result.idle        <= !found;
      result.completed   <= done_now;
      result.wait_ticks  <= done_now ? (now_new - best.arrival - best.burst) : 16'd0;
      result.now_tick    <= now_new;
    end
  end

  a_strobe_from_update: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_UPD)
    else $error("result strobe without an update cycle");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.idle) |->
      (!result.completed && result.wait_ticks == 16'd0 && result.chosen_slot == 4'd0))
    else $error("idle result carries service fields");

  a_now_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.now_tick == tick)
    else $error("reported time differs from time counter");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> busy)
    else $error("tick item accepted but block not busy");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> !busy)
    else $error("load item made the block busy");

endmodule
`default_nettype wire
